// ----- sv/assert_macros.svh -----
// assertion macros shared by the scaled pixel fetch rtl
// expects clk and rst_n in the scope of every use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define BSPF_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`define BSPF_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define BSPF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define BSPF_ASSERT(lbl, cond, msg)
`define BSPF_ASSERT_IMPL(lbl, ante, cons, msg)
`define BSPF_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ----- sv/bspf_pkg.sv -----
// shared types, widths and codes for the scaled bmp pixel fetch block
// no dependencies
`default_nettype none
package bspf_pkg;

  localparam int SCREEN_WIDTH_DEF  = 240;
  localparam int SCREEN_HEIGHT_DEF = 135;
  localparam int MAX_SIDE_DEF      = 4095;
  localparam int QUEUE_DEPTH_DEF   = 2;

  localparam int COLOR_W   = 8;
  localparam int RGB_W     = 16;
  localparam int STATUS_W  = 2;
  localparam int DIM_W     = 10;
  localparam int SIDE_W    = 12;
  localparam int HEIGHT_W  = 13;
  localparam int STRIDE_W  = 14;
  localparam int SCALE_W   = 16;
  localparam int ADDR_W    = 32;
  localparam int OFFSET_W  = 24;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam int MUL_A_W = DIM_W + SCALE_W;
  localparam int MUL_B_W = 32;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;
  localparam int RECIP_SHIFT = 35;
  localparam logic [MUL_B_W-1:0] RECIP_TEN = 32'hCCCC_CCCD;
  localparam int SRC_W = MUL_P_W - RECIP_SHIFT;
  localparam int DIV_SHIFT = SCALE_W + DIM_W;

  localparam logic [15:0] BMP_SIGNATURE = 16'h4D42;
  localparam logic [15:0] BMP_DEPTH     = 16'd24;
  localparam logic [SCALE_W-1:0] SCALE_UNIT = SCALE_W'(10);

  localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_BAD_SIG  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_BAD_FMT  = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_IDLE_PIX = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_SIGNATURE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BIT_DEPTH    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COMPRESSION  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PIXEL_OFFSET = 3'd5;

  localparam logic [15:0]          RESET_SIGNATURE = 16'h4D42;
  localparam logic [15:0]          RESET_DEPTH     = 16'd24;
  localparam logic [SIDE_W-1:0]    RESET_WIDTH     = 12'd240;
  localparam logic [HEIGHT_W-1:0]  RESET_HEIGHT    = 13'd135;
  localparam logic [OFFSET_W-1:0]  RESET_OFFSET    = 24'd54;

  typedef struct packed {
    logic                  is_pixel;
    logic [RGB_W-1:0]      rgb565;
  } bspf_cmd_t;

  typedef struct packed {
    logic                  we;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] wdata;
  } bspf_cfg_t;

endpackage
`default_nettype wire

// ----- sv/bspf_in_if.sv -----
// input channel: action word plus fetched pixel bytes
// depends on bspf_pkg
`default_nettype none
interface bspf_in_if;
  logic                          valid;
  logic                          ready;
  logic                          action;
  logic [bspf_pkg::COLOR_W-1:0]  blue;
  logic [bspf_pkg::COLOR_W-1:0]  green;
  logic [bspf_pkg::COLOR_W-1:0]  red;

  modport source (output valid, action, blue, green, red, input ready);
  modport sink   (input valid, action, blue, green, red, output ready);
endinterface
`default_nettype wire

// ----- sv/bspf_out_if.sv -----
// result channel: status, window, next fetch address and pixel
// depends on bspf_pkg
`default_nettype none
interface bspf_out_if;
  logic                          valid;
  logic                          ready;
  logic [bspf_pkg::STATUS_W-1:0] status;
  logic [bspf_pkg::DIM_W-1:0]    win_x0;
  logic [bspf_pkg::DIM_W-1:0]    win_y0;
  logic [bspf_pkg::DIM_W-1:0]    win_x1;
  logic [bspf_pkg::DIM_W-1:0]    win_y1;
  logic                          fetch_valid;
  logic [bspf_pkg::ADDR_W-1:0]   fetch_address;
  logic                          pixel_valid;
  logic [bspf_pkg::RGB_W-1:0]    rgb565;
  logic                          last;

  modport source (output valid, status, win_x0, win_y0, win_x1, win_y1, fetch_valid,
                  fetch_address, pixel_valid, rgb565, last, input ready);
  modport sink   (input valid, status, win_x0, win_y0, win_x1, win_y1, fetch_valid,
                  fetch_address, pixel_valid, rgb565, last, output ready);
endinterface
`default_nettype wire

// ----- sv/bspf_front.sv -----
// front end: takes input words, classifies them and packs pixels to rgb565
// depends on bspf_pkg and bspf_in_if
`default_nettype none
module bspf_front (
  bspf_in_if.sink               in_ch,
  input  wire logic             q_full,
  output logic                  q_push,
  output bspf_pkg::bspf_cmd_t   q_push_data
);

  assign in_ch.ready = !q_full;
  assign q_push      = in_ch.valid && !q_full;

  always_comb begin
    q_push_data.is_pixel = in_ch.action;
    q_push_data.rgb565   = {in_ch.red[7:3], in_ch.green[7:2], in_ch.blue[7:3]};
  end

endmodule
`default_nettype wire

// ----- sv/bspf_fifo.sv -----
// short command queue between front end and back end
// depends on bspf_pkg
`default_nettype none
module bspf_fifo #(
  parameter int DEPTH = bspf_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 push,
  input  wire bspf_pkg::bspf_cmd_t  push_data,
  output logic                      full,
  input  wire logic                 pop,
  output logic                      q_valid,
  output bspf_pkg::bspf_cmd_t       q_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  bspf_pkg::bspf_cmd_t mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push;
  logic             do_pop;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign q_valid = (count_r != '0);
  assign q_data  = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && q_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

endmodule
`default_nettype wire

// ----- sv/bspf_div.sv -----
// scale quotient unit: divides by screen width or height with a reciprocal multiply
// one registered product per start; depends on bspf_pkg
`default_nettype none
module bspf_div #(
  parameter int DIVISOR_A = bspf_pkg::SCREEN_WIDTH_DEF,
  parameter int DIVISOR_B = bspf_pkg::SCREEN_HEIGHT_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic                          sel_b,
  input  wire logic [bspf_pkg::SCALE_W-1:0]  dividend,
  output logic                               done,
  output logic [bspf_pkg::SCALE_W-1:0]       quotient
);

  localparam int NUM_W  = bspf_pkg::SCALE_W;
  localparam int SHIFT  = bspf_pkg::DIV_SHIFT;
  localparam int REC_W  = SHIFT + 1;
  localparam int PROD_W = NUM_W + REC_W;
  localparam logic [REC_W-1:0] RECIP_A =
    REC_W'(((64'd1 << SHIFT) + 64'(DIVISOR_A) - 64'd1) / 64'(DIVISOR_A));
  localparam logic [REC_W-1:0] RECIP_B =
    REC_W'(((64'd1 << SHIFT) + 64'(DIVISOR_B) - 64'd1) / 64'(DIVISOR_B));

  logic              done_r;
  logic [PROD_W-1:0] prod_r;
  logic [REC_W-1:0]  recip;

  assign recip    = sel_b ? RECIP_B : RECIP_A;
  assign done     = done_r;
  assign quotient = prod_r[SHIFT +: NUM_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r <= 1'b0;
    end else begin
      done_r <= start;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      prod_r <= dividend * recip;
    end
  end

endmodule
`default_nettype wire

// ----- sv/bspf_back.sv -----
// back end: header registers, frame sequencer, address unit and result register
// depends on bspf_pkg, bspf_out_if, bspf_div and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"
module bspf_back #(
  parameter int SCREEN_WIDTH  = bspf_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = bspf_pkg::SCREEN_HEIGHT_DEF,
  parameter int MAX_SIDE      = bspf_pkg::MAX_SIDE_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire bspf_pkg::bspf_cfg_t  cfg,
  input  wire logic                 q_valid,
  input  wire bspf_pkg::bspf_cmd_t  q_data,
  output logic                      q_pop,
  bspf_out_if.source                out_ch
);

  localparam int DIM_W    = bspf_pkg::DIM_W;
  localparam int SIDE_W   = bspf_pkg::SIDE_W;
  localparam int HEIGHT_W = bspf_pkg::HEIGHT_W;
  localparam int STRIDE_W = bspf_pkg::STRIDE_W;
  localparam int SCALE_W  = bspf_pkg::SCALE_W;
  localparam int ADDR_W   = bspf_pkg::ADDR_W;
  localparam int MUL_A_W  = bspf_pkg::MUL_A_W;
  localparam int MUL_B_W  = bspf_pkg::MUL_B_W;
  localparam int MUL_P_W  = bspf_pkg::MUL_P_W;
  localparam int SRC_W    = bspf_pkg::SRC_W;
  localparam int SHIFT    = bspf_pkg::RECIP_SHIFT;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CGO   = 4'd1;
  localparam logic [3:0] S_CWAIT = 4'd2;
  localparam logic [3:0] S_RGO   = 4'd3;
  localparam logic [3:0] S_RWAIT = 4'd4;
  localparam logic [3:0] S_SX1   = 4'd5;
  localparam logic [3:0] S_SX2   = 4'd6;
  localparam logic [3:0] S_SY1   = 4'd7;
  localparam logic [3:0] S_SY2   = 4'd8;
  localparam logic [3:0] S_Y     = 4'd9;
  localparam logic [3:0] S_ADD   = 4'd10;
  localparam logic [3:0] S_DONE  = 4'd11;

  // header registers
  logic [15:0]                    sig_r;
  logic [15:0]                    depth_r;
  logic [31:0]                    comp_r;
  logic [SIDE_W-1:0]              width_r;
  logic [HEIGHT_W-1:0]            height_r;
  logic [bspf_pkg::OFFSET_W-1:0]  offset_r;

  // frame state
  logic [3:0]          state_r;
  logic                active_r;
  logic                top_first_r;
  logic [SIDE_W-1:0]   height_mag_r;
  logic [STRIDE_W-1:0] row_stride_r;
  logic [SCALE_W-1:0]  scale_col_r;
  logic [SCALE_W-1:0]  scale_row_r;
  logic [DIM_W-1:0]    draw_cols_r;
  logic [DIM_W-1:0]    draw_rows_r;
  logic [DIM_W-1:0]    col_count_r;
  logic [DIM_W-1:0]    row_count_r;

  // pending result
  logic [bspf_pkg::STATUS_W-1:0] pend_status_r;
  logic                          pend_start_r;
  logic                          pend_fetch_r;
  logic                          pend_pixel_r;
  logic                          pend_last_r;
  logic [bspf_pkg::RGB_W-1:0]    pend_rgb_r;
  logic [ADDR_W-1:0]             addr_r;
  logic [SRC_W-1:0]              sx_r;
  logic [MUL_P_W-1:0]            prod_r;
  logic                          out_valid_r;

  logic                  h_neg;
  logic [HEIGHT_W-1:0]   h_mag;
  logic                  sig_bad;
  logic                  fmt_bad;
  logic [DIM_W-1:0]      col_inc;
  logic                  col_wrap;
  logic [DIM_W-1:0]      row_inc;
  logic                  frame_end;
  logic                  out_load;
  logic                  div_start;
  logic [SCALE_W-1:0]    div_dividend;
  logic                  div_sel_b;
  logic                  div_done;
  logic [SCALE_W-1:0]    div_quot;
  logic [MUL_A_W-1:0]    mul_a;
  logic [MUL_B_W-1:0]    mul_b;
  logic [SRC_W-1:0]      src_q;
  logic [SIDE_W-1:0]     y_row;
  logic [ADDR_W-1:0]     sx3;
  logic [STRIDE_W-1:0]   stride_raw;
  logic [DIM_W-1:0]      win_x0;
  logic [DIM_W-1:0]      win_y0;

  assign h_neg   = height_r[HEIGHT_W-1];
  assign h_mag   = h_neg ? HEIGHT_W'(HEIGHT_W'(0) - height_r) : height_r;
  assign sig_bad = (sig_r != bspf_pkg::BMP_SIGNATURE);
  assign fmt_bad = (depth_r != bspf_pkg::BMP_DEPTH) || (comp_r != '0) ||
                   (width_r == '0) || (h_mag == '0) ||
                   ({1'b0, width_r} > HEIGHT_W'(MAX_SIDE)) || (h_mag > HEIGHT_W'(MAX_SIDE));
  assign stride_raw = STRIDE_W'({width_r, 1'b0}) + STRIDE_W'(width_r) + STRIDE_W'(3);

  assign col_inc   = col_count_r + DIM_W'(1);
  assign col_wrap  = (col_inc >= draw_cols_r);
  assign row_inc   = col_wrap ? row_count_r + DIM_W'(1) : row_count_r;
  assign frame_end = (row_inc >= draw_rows_r);

  assign q_pop    = (state_r == S_IDLE) && q_valid;
  assign out_load = (state_r == S_DONE) && (!out_valid_r || out_ch.ready);

  assign div_start    = (state_r == S_CGO) || (state_r == S_RGO);
  assign div_dividend = (state_r == S_CGO) ?
                        SCALE_W'({width_r, 3'b000}) + SCALE_W'({width_r, 1'b0}) :
                        SCALE_W'({height_mag_r, 3'b000}) + SCALE_W'({height_mag_r, 1'b0});
  assign div_sel_b    = (state_r == S_RGO);

  bspf_div #(
    .DIVISOR_A (SCREEN_WIDTH),
    .DIVISOR_B (SCREEN_HEIGHT)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .sel_b    (div_sel_b),
    .dividend (div_dividend),
    .done     (div_done),
    .quotient (div_quot)
  );

  // shared multiplier, one product per cycle
  assign src_q = prod_r[MUL_P_W-1:SHIFT];
  assign y_row = top_first_r ? src_q[SIDE_W-1:0]
                             : height_mag_r - SIDE_W'(1) - src_q[SIDE_W-1:0];
  assign sx3   = ADDR_W'(sx_r) + ADDR_W'({sx_r, 1'b0});

  always_comb begin
    case (state_r)
      S_SX1: begin
        mul_a = MUL_A_W'(col_count_r);
        mul_b = MUL_B_W'(scale_col_r);
      end
      S_SY1: begin
        mul_a = MUL_A_W'(row_count_r);
        mul_b = MUL_B_W'(scale_row_r);
      end
      S_SX2, S_SY2: begin
        mul_a = prod_r[MUL_A_W-1:0];
        mul_b = bspf_pkg::RECIP_TEN;
      end
      S_Y: begin
        mul_a = MUL_A_W'(y_row);
        mul_b = MUL_B_W'(row_stride_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sig_r    <= bspf_pkg::RESET_SIGNATURE;
      depth_r  <= bspf_pkg::RESET_DEPTH;
      comp_r   <= '0;
      width_r  <= bspf_pkg::RESET_WIDTH;
      height_r <= bspf_pkg::RESET_HEIGHT;
      offset_r <= bspf_pkg::RESET_OFFSET;
    end else if (cfg.we) begin
      case (cfg.index)
        bspf_pkg::REG_SIGNATURE:    sig_r    <= cfg.wdata[15:0];
        bspf_pkg::REG_BIT_DEPTH:    depth_r  <= cfg.wdata[15:0];
        bspf_pkg::REG_COMPRESSION:  comp_r   <= cfg.wdata;
        bspf_pkg::REG_IMAGE_WIDTH:  width_r  <= cfg.wdata[SIDE_W-1:0];
        bspf_pkg::REG_IMAGE_HEIGHT: height_r <= cfg.wdata[HEIGHT_W-1:0];
        bspf_pkg::REG_PIXEL_OFFSET: offset_r <= cfg.wdata[bspf_pkg::OFFSET_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      active_r     <= 1'b0;
      top_first_r  <= 1'b0;
      height_mag_r <= '0;
      row_stride_r <= '0;
      scale_col_r  <= bspf_pkg::SCALE_UNIT;
      scale_row_r  <= bspf_pkg::SCALE_UNIT;
      draw_cols_r  <= '0;
      draw_rows_r  <= '0;
      col_count_r  <= '0;
      row_count_r  <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            pend_status_r <= bspf_pkg::STATUS_OK;
            pend_start_r  <= 1'b0;
            pend_fetch_r  <= 1'b0;
            pend_pixel_r  <= 1'b0;
            pend_last_r   <= 1'b0;
            pend_rgb_r    <= q_data.rgb565;
            state_r       <= S_DONE;
            if (!q_data.is_pixel) begin
              active_r <= 1'b0;
              if (sig_bad) begin
                pend_status_r <= bspf_pkg::STATUS_BAD_SIG;
              end else if (fmt_bad) begin
                pend_status_r <= bspf_pkg::STATUS_BAD_FMT;
              end else begin
                top_first_r  <= h_neg;
                height_mag_r <= h_mag[SIDE_W-1:0];
                row_stride_r <= {stride_raw[STRIDE_W-1:2], 2'b00};
                draw_cols_r  <= (width_r > SIDE_W'(SCREEN_WIDTH)) ?
                                DIM_W'(SCREEN_WIDTH) : width_r[DIM_W-1:0];
                draw_rows_r  <= (h_mag > HEIGHT_W'(SCREEN_HEIGHT)) ?
                                DIM_W'(SCREEN_HEIGHT) : h_mag[DIM_W-1:0];
                col_count_r  <= '0;
                row_count_r  <= '0;
                active_r     <= 1'b1;
                pend_start_r <= 1'b1;
                pend_fetch_r <= 1'b1;
                state_r      <= S_CGO;
              end
            end else if (!active_r) begin
              pend_status_r <= bspf_pkg::STATUS_IDLE_PIX;
            end else begin
              pend_pixel_r <= 1'b1;
              if (frame_end) begin
                active_r    <= 1'b0;
                col_count_r <= '0;
                row_count_r <= '0;
                pend_last_r <= 1'b1;
              end else begin
                col_count_r  <= col_wrap ? '0 : col_inc;
                row_count_r  <= row_inc;
                pend_fetch_r <= 1'b1;
                state_r      <= S_SX1;
              end
            end
          end
        end
        S_CGO: state_r <= S_CWAIT;
        S_CWAIT: begin
          if (div_done) begin
            scale_col_r <= (width_r > SIDE_W'(SCREEN_WIDTH)) ? div_quot : bspf_pkg::SCALE_UNIT;
            state_r     <= S_RGO;
          end
        end
        S_RGO: state_r <= S_RWAIT;
        S_RWAIT: begin
          if (div_done) begin
            scale_row_r <= (height_mag_r > SIDE_W'(SCREEN_HEIGHT)) ?
                           div_quot : bspf_pkg::SCALE_UNIT;
            state_r     <= S_SX1;
          end
        end
        S_SX1: state_r <= S_SX2;
        S_SX2: state_r <= S_SY1;
        S_SY1: begin
          sx_r    <= src_q;
          state_r <= S_SY2;
        end
        S_SY2: state_r <= S_Y;
        S_Y:   state_r <= S_ADD;
        S_ADD: begin
          addr_r  <= ADDR_W'(offset_r) + prod_r[ADDR_W-1:0] + sx3;
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (out_load) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase

      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign win_x0 = DIM_W'((DIM_W'(SCREEN_WIDTH) - draw_cols_r) >> 1);
  assign win_y0 = DIM_W'((DIM_W'(SCREEN_HEIGHT) - draw_rows_r) >> 1);

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_ch.status        <= pend_status_r;
      out_ch.win_x0        <= pend_start_r ? win_x0 : '0;
      out_ch.win_y0        <= pend_start_r ? win_y0 : '0;
      out_ch.win_x1        <= pend_start_r ? win_x0 + draw_cols_r - DIM_W'(1) : '0;
      out_ch.win_y1        <= pend_start_r ? win_y0 + draw_rows_r - DIM_W'(1) : '0;
      out_ch.fetch_valid   <= pend_fetch_r;
      out_ch.fetch_address <= pend_fetch_r ? addr_r : '0;
      out_ch.pixel_valid   <= pend_pixel_r;
      out_ch.rgb565        <= pend_pixel_r ? pend_rgb_r : '0;
      out_ch.last          <= pend_last_r;
    end
  end

  assign out_ch.valid = out_valid_r;

  `BSPF_ASSERT_IMPL(a_active_dims, active_r, (draw_cols_r != '0) && (draw_rows_r != '0), "active frame with empty window")
  `BSPF_ASSERT_IMPL(a_active_count, active_r, (col_count_r < draw_cols_r) && (row_count_r < draw_rows_r), "frame counter past window")
  `BSPF_ASSERT_NEXT(a_result_loads, (state_r == S_DONE) && !out_valid_r, out_valid_r, "finished word not presented")
  `BSPF_ASSERT_IMPL(a_pop_nonempty, q_pop, q_valid, "pop from empty queue")

endmodule
`default_nettype wire

// ----- sv/bmp_scaled_pixel_fetch_rgb565.sv -----
// A 24-bit BMP header is written through the cfg port; a start word checks it and answers with
// the centred display window and the file byte address of the first source pixel, and each
// pixel word (fetched blue, green, red bytes) answers with the rgb565 pixel, the next source
// address and a last flag. Input words go through a short queue, so the input side keeps
// taking words until it is full while a result waits at the output register. In the back end
// a pixel word is dequeued, runs the column and row scale products, their divide-by-ten
// reciprocal products and row times stride on the single shared multiplier, takes the final
// add and loads the output register. A good start word runs the two per-axis scale
// quotients, each one reciprocal product by the screen side, before those steps. Error words,
// pixels while idle and the final pixel of a frame go from dequeue to the output register.
// depends on bspf_pkg, bspf_in_if, bspf_out_if, bspf_front, bspf_fifo, bspf_back
`default_nettype none
module bmp_scaled_pixel_fetch_rgb565 #(
  parameter int SCREEN_WIDTH  = bspf_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = bspf_pkg::SCREEN_HEIGHT_DEF,
  parameter int MAX_SIDE      = bspf_pkg::MAX_SIDE_DEF,
  parameter int QUEUE_DEPTH   = bspf_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  bspf_in_if.sink                                in_ch,
  bspf_out_if.source                             out_ch,
  input  wire logic                              cfg_we,
  input  wire logic [bspf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [bspf_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  bspf_pkg::bspf_cfg_t cfg;
  bspf_pkg::bspf_cmd_t push_data;
  bspf_pkg::bspf_cmd_t q_data;
  logic                push;
  logic                full;
  logic                pop;
  logic                q_valid;

  always_comb begin
    cfg.we    = cfg_we;
    cfg.index = cfg_index;
    cfg.wdata = cfg_wdata;
  end

  bspf_front u_front (
    .in_ch       (in_ch),
    .q_full      (full),
    .q_push      (push),
    .q_push_data (push_data)
  );

  bspf_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .q_valid   (q_valid),
    .q_data    (q_data)
  );

  bspf_back #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT),
    .MAX_SIDE      (MAX_SIDE)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .q_valid (q_valid),
    .q_data  (q_data),
    .q_pop   (pop),
    .out_ch  (out_ch)
  );

endmodule
`default_nettype wire

// ----- bench/tb_bmp_scaled_pixel_fetch_rgb565.sv -----
`timescale 1ns / 100ps
// testbench for bmp_scaled_pixel_fetch_rgb565: header writes, start and pixel words, each
// result word predicted by an in-bench model of the fetcher and compared field by field
// depends on bspf_pkg, bspf_in_if, bspf_out_if and the block rtl
module tb_bmp_scaled_pixel_fetch_rgb565;
  import bspf_pkg::*;

  localparam int SCR_W    = SCREEN_WIDTH_DEF;
  localparam int SCR_H    = SCREEN_HEIGHT_DEF;
  localparam int SIDE_MAX = MAX_SIDE_DEF;
  localparam int TENTHS   = 10;

  localparam logic ACT_START = 1'b0;
  localparam logic ACT_PIXEL = 1'b1;

  localparam int HOLD_OFF_CYCLES = 400;
  localparam int STALL_LIMIT     = 4000;
  localparam int SETTLE_CYCLES   = 100;
  localparam int RANDOM_WORDS    = 620;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [DIM_W-1:0]    win_x0;
    logic [DIM_W-1:0]    win_y0;
    logic [DIM_W-1:0]    win_x1;
    logic [DIM_W-1:0]    win_y1;
    logic                fetch_valid;
    logic [ADDR_W-1:0]   fetch_address;
    logic                pixel_valid;
    logic [RGB_W-1:0]    rgb565;
    logic                last;
  } fetch_word_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  bspf_in_if  in_ch();
  bspf_out_if out_ch();

  bmp_scaled_pixel_fetch_rgb565 dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .out_ch(out_ch),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always #4 clk = ~clk;

  // header registers as the block holds them
  logic [15:0]         hdr_signature;
  logic [15:0]         hdr_depth;
  logic [31:0]         hdr_compression;
  logic [SIDE_W-1:0]   hdr_width;
  logic [HEIGHT_W-1:0] hdr_height;
  logic [OFFSET_W-1:0] hdr_offset;

  // frame walk state
  bit          frame_open;
  bit          rows_top_first;
  int unsigned src_rows;
  int unsigned stride;
  int unsigned col_step;
  int unsigned row_step;
  int unsigned draw_w;
  int unsigned draw_h;
  int unsigned col_pos;
  int unsigned row_pos;

  fetch_word_t words_due[$];
  int fail_count   = 0;
  int words_sent   = 0;
  int idle_cycles  = 0;
  bit steady       = 1'b0;
  bit hold_off_req = 1'b0;

  function automatic logic [ADDR_W-1:0] source_byte(int unsigned col, int unsigned row);
    int unsigned sy;
    int unsigned sx;
    int unsigned y;
    sy = row * row_step / TENTHS;
    sx = col * col_step / TENTHS;
    y = rows_top_first ? sy : src_rows - 1 - sy;
    return hdr_offset + y * stride + sx * 3;
  endfunction

  function automatic fetch_word_t fetch_model(logic action, logic [7:0] b, logic [7:0] g,
                                              logic [7:0] r);
    fetch_word_t res;
    logic [HEIGHT_W-1:0] mag_bits;
    int unsigned mag;
    int unsigned w;
    int unsigned x0;
    int unsigned y0;
    res = '0;
    if (action == ACT_START) begin
      mag_bits = hdr_height[HEIGHT_W-1] ? -hdr_height : hdr_height;
      mag = mag_bits;
      w = hdr_width;
      frame_open = 1'b0;
      if (hdr_signature != BMP_SIGNATURE) begin
        res.status = STATUS_BAD_SIG;
      end else if (hdr_depth != BMP_DEPTH || hdr_compression != 0 || w == 0 || mag == 0 ||
                   w > SIDE_MAX || mag > SIDE_MAX) begin
        res.status = STATUS_BAD_FMT;
      end else begin
        rows_top_first = hdr_height[HEIGHT_W-1];
        src_rows = mag;
        stride = (w * 3 + 3) & ~32'd3;
        col_step = (w > SCR_W) ? w * TENTHS / SCR_W : TENTHS;
        row_step = (mag > SCR_H) ? mag * TENTHS / SCR_H : TENTHS;
        draw_w = (w > SCR_W) ? SCR_W : w;
        draw_h = (mag > SCR_H) ? SCR_H : mag;
        col_pos = 0;
        row_pos = 0;
        frame_open = 1'b1;
        x0 = (SCR_W - draw_w) / 2;
        y0 = (SCR_H - draw_h) / 2;
        res.status = STATUS_OK;
        res.win_x0 = DIM_W'(x0);
        res.win_y0 = DIM_W'(y0);
        res.win_x1 = DIM_W'(x0 + draw_w - 1);
        res.win_y1 = DIM_W'(y0 + draw_h - 1);
        res.fetch_valid = 1'b1;
        res.fetch_address = source_byte(0, 0);
      end
    end else if (!frame_open) begin
      res.status = STATUS_IDLE_PIX;
    end else begin
      res.pixel_valid = 1'b1;
      res.rgb565 = {r[7:3], g[7:2], b[7:3]};
      col_pos++;
      if (col_pos >= draw_w) begin
        col_pos = 0;
        row_pos++;
      end
      if (row_pos >= draw_h) begin
        frame_open = 1'b0;
        col_pos = 0;
        row_pos = 0;
        res.last = 1'b1;
      end else begin
        res.fetch_valid = 1'b1;
        res.fetch_address = source_byte(col_pos, row_pos);
      end
    end
    return res;
  endfunction

  function automatic int gap_cycles();
    int pick;
    if (steady) return 0;
    pick = $urandom_range(0, 99);
    if (pick < 55) return 0;
    if (pick < 85) return $urandom_range(1, 3);
    if (pick < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic int stall_cycles();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) return $urandom_range(1, 3);
    if (pick < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      fail_count++;
    end
  endfunction

  task automatic send_word(logic action, logic [7:0] b, logic [7:0] g, logic [7:0] r);
    int gap;
    gap = gap_cycles();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.action <= action;
    in_ch.blue   <= b;
    in_ch.green  <= g;
    in_ch.red    <= r;
    do @(negedge clk); while (!in_ch.ready);
    words_due.push_back(fetch_model(action, b, g, r));
    words_sent++;
    @(posedge clk);
  endtask

  task automatic send_start();
    send_word(ACT_START, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
              8'($urandom_range(0, 255)));
  endtask

  task automatic send_pixels(int count);
    for (int i = 0; i < count; i++) begin
      send_word(ACT_PIXEL, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                8'($urandom_range(0, 255)));
    end
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (words_due.size() != 0) @(posedge clk);
  endtask

  task automatic set_header(logic [31:0] sig, logic [31:0] depth, logic [31:0] comp,
                            logic [31:0] width, logic [31:0] height, logic [31:0] offset);
    logic [CFG_IDX_W-1:0] order[6];
    logic [31:0] vals[6];
    order = '{REG_SIGNATURE, REG_BIT_DEPTH, REG_COMPRESSION, REG_IMAGE_WIDTH,
              REG_IMAGE_HEIGHT, REG_PIXEL_OFFSET};
    vals = '{sig, depth, comp, width, height, offset};
    for (int i = 0; i < 6; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= order[i];
      cfg_wdata <= vals[i];
      @(posedge clk);
      case (order[i])
        REG_SIGNATURE:    hdr_signature = vals[i][15:0];
        REG_BIT_DEPTH:    hdr_depth = vals[i][15:0];
        REG_COMPRESSION:  hdr_compression = vals[i];
        REG_IMAGE_WIDTH:  hdr_width = vals[i][SIDE_W-1:0];
        REG_IMAGE_HEIGHT: hdr_height = vals[i][HEIGHT_W-1:0];
        REG_PIXEL_OFFSET: hdr_offset = vals[i][OFFSET_W-1:0];
        default: ;
      endcase
    end
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic good_header(logic [31:0] width, logic [31:0] height, logic [31:0] offset);
    set_header(32'(BMP_SIGNATURE), 32'(BMP_DEPTH), 32'd0, width, height, offset);
  endtask

  task automatic test_idle_pixels();
    send_word(ACT_PIXEL, 8'h00, 8'h00, 8'h00);
    send_word(ACT_PIXEL, 8'hFF, 8'hFF, 8'hFF);
  endtask

  task automatic test_reset_header_frame();
    send_start();
    send_word(ACT_PIXEL, 8'h00, 8'h00, 8'h00);
    send_word(ACT_PIXEL, 8'hFF, 8'hFF, 8'hFF);
    // restart while a frame is open
    send_start();
    send_word(ACT_PIXEL, 8'hF8, 8'h04, 8'h07);
  endtask

  task automatic test_header_errors();
    drain();
    set_header(32'h0000_0000, 32'(BMP_DEPTH), 32'd0, 32'd240, 32'd135, 32'd54);
    send_start();
    send_pixels(1);
    drain();
    set_header(32'(BMP_SIGNATURE), 32'h0000_FFFF, 32'd0, 32'd240, 32'd135, 32'd54);
    send_start();
    drain();
    set_header(32'(BMP_SIGNATURE), 32'(BMP_DEPTH), 32'hFFFF_FFFF, 32'd240, 32'd135, 32'd54);
    send_start();
    drain();
    good_header(32'd0, 32'd135, 32'd54);
    send_start();
    drain();
    good_header(32'd240, 32'd0, 32'd54);
    send_start();
    drain();
    good_header(32'd240, 32'h0000_1000, 32'd54);
    send_start();
  endtask

  task automatic test_small_frames();
    drain();
    good_header(32'd1, 32'd1, 32'd0);
    send_start();
    send_pixels(2);
    drain();
    good_header(32'd3, 32'h0000_1FFE, 32'h00FF_FFFF);
    send_start();
    send_pixels(6);
    drain();
    good_header(32'd4095, 32'h0000_1001, 32'd54);
    send_start();
    send_pixels(2);
  endtask

  task automatic test_steady_stream();
    drain();
    steady = 1'b1;
    good_header(32'd6, 32'd3, 32'd1000);
    send_start();
    send_pixels(19);
    drain();
    steady = 1'b0;
  endtask

  task automatic test_backpressure();
    drain();
    good_header(32'd8, 32'd4, 32'd100);
    send_start();
    hold_off_req = 1'b1;
    send_pixels(30);
    drain();
  endtask

  task automatic test_random_frames();
    int stop_at;
    int shape;
    int w;
    int h;
    int pixels;
    int mode;
    bit first;
    bit dirty;
    logic [31:0] sig;
    logic [31:0] depth;
    logic [31:0] comp;
    logic [31:0] offset;
    logic [31:0] w_raw;
    logic [31:0] h_raw;
    stop_at = words_sent + RANDOM_WORDS;
    first = 1'b1;
    while (words_sent < stop_at) begin
      if (first || $urandom_range(0, 9) < 7) begin
        shape = $urandom_range(0, 99);
        w = $urandom_range(1, 12);
        h = $urandom_range(1, 8);
        if (shape < 5) begin
          w = $urandom_range(SCR_W + 1, SIDE_MAX);
          h = 1;
        end else if (shape < 10) begin
          w = $urandom_range(1, 2);
          h = $urandom_range(SCR_H + 1, SIDE_MAX);
        end
        if ($urandom_range(0, 1)) h = -h;
        sig = 32'(BMP_SIGNATURE);
        depth = 32'(BMP_DEPTH);
        comp = 32'd0;
        case ($urandom_range(0, 3))
          0: offset = 32'd0;
          1: offset = 32'h00FF_FFFF;
          default: offset = 32'($urandom_range(0, 32'h00FF_FFFF));
        endcase
        if (shape >= 88) begin
          case ($urandom_range(0, 5))
            0: sig = $urandom_range(0, 65535);
            1: depth = $urandom_range(0, 65535);
            2: comp = $urandom();
            3: w = 0;
            4: h = 0;
            default: h = -4096;
          endcase
        end
        w_raw = {20'd0, 12'(w)};
        h_raw = {19'd0, 13'(h)};
        dirty = ($urandom_range(0, 4) == 0);
        if (dirty) begin
          sig = sig | ($urandom() & 32'hFFFF_0000);
          depth = depth | ($urandom() & 32'hFFFF_0000);
          w_raw = w_raw | ($urandom() & 32'hFFFF_F000);
          h_raw = h_raw | ($urandom() & 32'hFFFF_E000);
          offset = offset | ($urandom() & 32'hFF00_0000);
        end
        drain();
        set_header(sig, depth, comp, w_raw, h_raw, offset);
        first = 1'b0;
      end
      send_start();
      if (!frame_open) begin
        send_pixels($urandom_range(0, 2));
      end else begin
        pixels = draw_w * draw_h;
        mode = $urandom_range(0, 9);
        if (mode < 7) begin
          send_pixels(pixels + $urandom_range(0, 2));
        end else if (mode < 9) begin
          send_pixels($urandom_range(0, pixels - 1));
        end else begin
          send_pixels($urandom_range(0, pixels - 1));
          send_start();
          send_pixels(pixels);
        end
      end
    end
  endtask

  // receiver: random ready with long hold-off on request
  initial begin
    out_ch.ready = 1'b0;
    @(posedge clk);
    forever begin
      if (hold_off_req) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_off_req = 1'b0;
      end else if (steady) begin
        out_ch.ready <= 1'b1;
        @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 30)) @(posedge clk);
        out_ch.ready <= 1'b0;
        repeat (stall_cycles()) @(posedge clk);
      end
    end
  end

  // result check, sampled at the falling clock edge ahead of the accepting edge
  always @(negedge clk) begin
    fetch_word_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (words_due.size() == 0) begin
        $error("result word with no expected word waiting");
        fail_count++;
      end else begin
        want = words_due.pop_front();
        check_field("status", 32'(want.status), 32'(out_ch.status));
        check_field("win_x0", 32'(want.win_x0), 32'(out_ch.win_x0));
        check_field("win_y0", 32'(want.win_y0), 32'(out_ch.win_y0));
        check_field("win_x1", 32'(want.win_x1), 32'(out_ch.win_x1));
        check_field("win_y1", 32'(want.win_y1), 32'(out_ch.win_y1));
        check_field("fetch_valid", 32'(want.fetch_valid), 32'(out_ch.fetch_valid));
        check_field("fetch_address", want.fetch_address, out_ch.fetch_address);
        check_field("pixel_valid", 32'(want.pixel_valid), 32'(out_ch.pixel_valid));
        check_field("rgb565", 32'(want.rgb565), 32'(out_ch.rgb565));
        check_field("last", 32'(want.last), 32'(out_ch.last));
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(negedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("bmp_scaled_pixel_fetch_rgb565 test failed");
        $finish;
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.action = ACT_START;
    in_ch.blue = '0;
    in_ch.green = '0;
    in_ch.red = '0;
    cfg_we = 1'b0;
    cfg_index = REG_SIGNATURE;
    cfg_wdata = '0;
    hdr_signature = RESET_SIGNATURE;
    hdr_depth = RESET_DEPTH;
    hdr_compression = '0;
    hdr_width = RESET_WIDTH;
    hdr_height = RESET_HEIGHT;
    hdr_offset = RESET_OFFSET;
    frame_open = 1'b0;
    rows_top_first = 1'b0;
    src_rows = 0;
    stride = 0;
    col_step = TENTHS;
    row_step = TENTHS;
    draw_w = 0;
    draw_h = 0;
    col_pos = 0;
    row_pos = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_idle_pixels();
    test_reset_header_frame();
    test_header_errors();
    test_small_frames();
    test_steady_stream();
    test_backpressure();
    test_random_frames();

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("bmp_scaled_pixel_fetch_rgb565 test passed");
    end else begin
      $display("bmp_scaled_pixel_fetch_rgb565 test failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+sv
sv/bspf_pkg.sv
sv/bspf_in_if.sv
sv/bspf_out_if.sv
sv/bspf_front.sv
sv/bspf_fifo.sv
sv/bspf_div.sv
sv/bspf_back.sv
sv/bmp_scaled_pixel_fetch_rgb565.sv
bench/tb_bmp_scaled_pixel_fetch_rgb565.sv
